// File: src/ctp_pkg.sv
// Shared constants, types and the arctangent table for the Cartesian-to-polar pipeline.
`default_nettype none

package ctp_pkg;

  localparam int SQRT_STEPS   = 16;
  localparam int TABLE_STAGES = 24;
  localparam int PRE_SHIFT    = 24;
  localparam int CW           = 43;   // CORDIC x/y width: Q8.8 scaled by 2^24 plus gain growth
  localparam int ZW           = 34;   // binary angle accumulator, 2^32 per turn
  localparam int RW           = 33;   // square root remainder and partial root

  localparam logic signed [ZW-1:0] HALF_TURN    = 34'sh0_8000_0000;
  localparam logic [30:0]          PI_Q29       = 31'd1686629713;
  localparam logic signed [15:0]   SENTINEL_Q11 = 16'sd20480;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] cz;
    logic [RW-1:0]        rem;
    logic [RW-1:0]        root;
    logic                 ang_ok;
    logic                 last;
  } ctp_iter_t;

  // atan(2^-i) in binary angle units.
  function automatic logic signed [ZW-1:0] atan_turns(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = 34'sd536870912;
      1:       val = 34'sd316933406;
      2:       val = 34'sd167458907;
      3:       val = 34'sd85004756;
      4:       val = 34'sd42667331;
      5:       val = 34'sd21354465;
      6:       val = 34'sd10679838;
      7:       val = 34'sd5340245;
      8:       val = 34'sd2670163;
      9:       val = 34'sd1335087;
      10:      val = 34'sd667544;
      11:      val = 34'sd333772;
      12:      val = 34'sd166886;
      13:      val = 34'sd83443;
      14:      val = 34'sd41722;
      15:      val = 34'sd20861;
      16:      val = 34'sd10430;
      17:      val = 34'sd5215;
      18:      val = 34'sd2608;
      19:      val = 34'sd1304;
      20:      val = 34'sd652;
      21:      val = 34'sd326;
      22:      val = 34'sd163;
      23:      val = 34'sd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: src/ctp_in_if.sv
// Input stream interface: one pixel of the x and y gradient images per transaction.
`default_nettype none

interface ctp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic               last_pixel;

  modport source (output valid, output x_value, output y_value, output last_pixel,
                  input ready);
  modport sink   (input valid, input x_value, input y_value, input last_pixel,
                  output ready);
endinterface

`default_nettype wire

// File: src/ctp_out_if.sv
// Result stream interface: modulus, argument and flags of one pixel per transaction.
`default_nettype none

interface ctp_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        magnitude;
  logic signed [15:0] angle;
  logic               angle_valid;
  logic               last_out;

  modport source (output valid, output magnitude, output angle, output angle_valid,
                  output last_out, input ready);
  modport sink   (input valid, input magnitude, input angle, input angle_valid,
                  input last_out, output ready);
endinterface

`default_nettype wire

// File: src/cartesian_to_polar_pixel.sv
// Pixel-rate Cartesian-to-polar converter: square root and CORDIC atan2 in one pipeline.
//
// in_ch takes one pixel (x_value, y_value in signed Q8.8, last_pixel) per transaction.
// out_ch gives per pixel the modulus in unsigned Q8.8, the argument in radians in
// signed Q5.11 and angle_valid; when x*x + y*y does not exceed min_mag_sq the angle
// is the sentinel 10.0 and angle_valid is low. last_out copies last_pixel.
// cfg_wr_en / cfg_wr_data write min_mag_sq (Q16.16); write it only while idle.
//
// From acceptance to out_ch.valid a pixel passes two front stages, one stage per square
// root digit and CORDIC rotation, and two stages for rounding and radian scaling. One
// pixel is accepted every cycle while out_ch is not stalled.
//
// All stages advance together. When out_ch holds a result that is not taken, the whole
// pipeline freezes and in_ch.ready drops in the same cycle, so nothing is lost or
// repeated. Reset clears every valid bit and sets min_mag_sq to zero.
`default_nettype none

module cartesian_to_polar_pixel import ctp_pkg::*; #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ctp_in_if.sink      in_ch,
  ctp_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int ROT  = (ROTATION_STAGES > TABLE_STAGES) ? TABLE_STAGES : ROTATION_STAGES;
  localparam int NSTG = (ROT > SQRT_STEPS) ? ROT : SQRT_STEPS;

  logic        adv;
  logic [31:0] min_mag_sq_r;
  logic        stg_v [0:NSTG];
  ctp_iter_t   stg_d [0:NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mag_sq_r <= '0;
    end else if (cfg_wr_en) begin
      min_mag_sq_r <= cfg_wr_data;
    end
  end

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  ctp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .valid_i    (in_ch.valid),
    .x_value    (in_ch.x_value),
    .y_value    (in_ch.y_value),
    .last_pixel (in_ch.last_pixel),
    .min_mag_sq (min_mag_sq_r),
    .valid_o    (stg_v[0]),
    .data_o     (stg_d[0])
  );

  for (genvar j = 0; j < NSTG; j++) begin : g_iter
    ctp_iter_stage #(
      .STEP    (j),
      .DO_SQRT (j < SQRT_STEPS),
      .DO_ROT  (j < ROT)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (stg_v[j]),
      .data_i  (stg_d[j]),
      .valid_o (stg_v[j+1]),
      .data_o  (stg_d[j+1])
    );
  end

  ctp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .valid_i     (stg_v[NSTG]),
    .data_i      (stg_d[NSTG]),
    .valid_o     (out_ch.valid),
    .magnitude   (out_ch.magnitude),
    .angle       (out_ch.angle),
    .angle_valid (out_ch.angle_valid),
    .last_out    (out_ch.last_out)
  );

endmodule

`default_nettype wire

// File: src/ctp_front.sv
// Front end: squares, sum of squares, threshold test and CORDIC half-turn pre-rotation.
`default_nettype none

module ctp_front import ctp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  logic signed [15:0] x_value,
  input  logic signed [15:0] y_value,
  input  logic               last_pixel,
  input  logic [31:0]        min_mag_sq,
  output logic               valid_o,
  output ctp_iter_t          data_o
);

  logic signed [31:0]    xsq_full;
  logic signed [31:0]    ysq_full;
  logic signed [CW-1:0]  xe;
  logic signed [CW-1:0]  ye;

  logic                  v1_r;
  logic [30:0]           xsq_r;
  logic [30:0]           ysq_r;
  logic signed [CW-1:0]  cx_r, cx_nxt;
  logic signed [CW-1:0]  cy_r, cy_nxt;
  logic signed [ZW-1:0]  cz_r, cz_nxt;
  logic                  last_r;

  logic [31:0]           sum;
  logic                  v2_r;
  ctp_iter_t             d2_r, d2_nxt;

  assign xsq_full = x_value * x_value;
  assign ysq_full = y_value * y_value;

  assign xe = CW'(x_value) <<< PRE_SHIFT;
  assign ye = CW'(y_value) <<< PRE_SHIFT;

  // A vector in the left half-plane is turned by half a turn before the iterations.
  always_comb begin
    cx_nxt = xe;
    cy_nxt = ye;
    cz_nxt = '0;
    if (x_value < 0) begin
      cx_nxt = -xe;
      cy_nxt = -ye;
      cz_nxt = (y_value >= 0) ? HALF_TURN : -HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xsq_r  <= xsq_full[30:0];
      ysq_r  <= ysq_full[30:0];
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      cz_r   <= cz_nxt;
      last_r <= last_pixel;
    end
  end

  assign sum = {1'b0, xsq_r} + {1'b0, ysq_r};

  always_comb begin
    d2_nxt.cx     = cx_r;
    d2_nxt.cy     = cy_r;
    d2_nxt.cz     = cz_r;
    d2_nxt.rem    = {1'b0, sum};
    d2_nxt.root   = '0;
    d2_nxt.ang_ok = (sum > min_mag_sq);
    d2_nxt.last   = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r <= d2_nxt;
    end
  end

  assign valid_o = v2_r;
  assign data_o  = d2_r;

endmodule

`default_nettype wire

// File: src/ctp_iter_stage.sv
// One pipeline stage: one square root digit step and one CORDIC vectoring rotation, each enabled by DO_SQRT / DO_ROT.
`default_nettype none

module ctp_iter_stage import ctp_pkg::*; #(
  parameter int STEP    = 0,
  parameter bit DO_SQRT = 1'b1,
  parameter bit DO_ROT  = 1'b1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      valid_i,
  input  ctp_iter_t data_i,
  output logic      valid_o,
  output ctp_iter_t data_o
);

  localparam int                   BIT_POS = DO_SQRT ? (30 - 2 * STEP) : 0;
  localparam logic [RW-1:0]        BIT     = RW'(1) << BIT_POS;
  localparam logic signed [ZW-1:0] ATAN    = atan_turns(STEP);

  logic                 v_r;
  ctp_iter_t            d_r, d_nxt;
  logic [RW-1:0]        trial;
  logic signed [CW-1:0] cx_s, cy_s, dx, dy;
  logic signed [ZW-1:0] cz_s;

  assign trial = data_i.root + BIT;
  assign cx_s  = data_i.cx;
  assign cy_s  = data_i.cy;
  assign cz_s  = data_i.cz;
  assign dx    = cy_s >>> STEP;
  assign dy    = cx_s >>> STEP;

  always_comb begin
    d_nxt = data_i;
    if (DO_SQRT) begin
      if (data_i.rem >= trial) begin
        d_nxt.rem  = data_i.rem - trial;
        d_nxt.root = (data_i.root >> 1) + BIT;
      end else begin
        d_nxt.root = data_i.root >> 1;
      end
    end
    // Rotate toward the positive x axis, accumulating the angle turned.
    if (DO_ROT) begin
      if (cy_s > 0) begin
        d_nxt.cx = cx_s + dx;
        d_nxt.cy = cy_s - dy;
        d_nxt.cz = cz_s + ATAN;
      end else begin
        d_nxt.cx = cx_s - dx;
        d_nxt.cy = cy_s + dy;
        d_nxt.cz = cz_s - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign valid_o = v_r;
  assign data_o  = d_r;

endmodule

`default_nettype wire

// File: src/ctp_back.sv
// Back end: rounds the modulus, scales the binary angle to radians and registers the result.
`default_nettype none

module ctp_back import ctp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  ctp_iter_t          data_i,
  output logic               valid_o,
  output logic [15:0]        magnitude,
  output logic signed [15:0] angle,
  output logic               angle_valid,
  output logic               last_out
);

  logic signed [16:0]  zh;
  logic signed [17:0]  zl;
  logic signed [31:0]  pi_s;
  logic signed [48:0]  ph_nxt, pl_nxt;
  logic [RW-1:0]       root_rnd;

  logic                v1_r;
  logic signed [48:0]  ph_r, pl_r;
  logic [15:0]         mag1_r;
  logic                ok1_r;
  logic                last1_r;

  logic signed [65:0]  tot;
  logic                v2_r;
  logic [15:0]         mag_r;
  logic signed [15:0]  ang_r, ang_nxt;
  logic                ok_r;
  logic                last_r;

  // The angle product is split into two partial products on the upper and lower halves.
  assign zh     = data_i.cz[ZW-1:17];
  assign zl     = $signed({1'b0, data_i.cz[16:0]});
  assign pi_s   = $signed({1'b0, PI_Q29});
  assign ph_nxt = zh * pi_s;
  assign pl_nxt = zl * pi_s;

  // Round to nearest: the remainder exceeds the root exactly when s >= r*r + r + 1.
  assign root_rnd = (data_i.rem > data_i.root) ? data_i.root + RW'(1) : data_i.root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r    <= ph_nxt;
      pl_r    <= pl_nxt;
      mag1_r  <= root_rnd[15:0];
      ok1_r   <= data_i.ang_ok;
      last1_r <= data_i.last;
    end
  end

  assign tot     = (66'(ph_r) <<< 17) + 66'(pl_r) + (66'sd1 <<< 48);
  assign ang_nxt = ok1_r ? tot[64:49] : SENTINEL_Q11;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag1_r;
      ang_r  <= ang_nxt;
      ok_r   <= ok1_r;
      last_r <= last1_r;
    end
  end

  assign valid_o     = v2_r;
  assign magnitude   = mag_r;
  assign angle       = ang_r;
  assign angle_valid = ok_r;
  assign last_out    = last_r;

endmodule

`default_nettype wire

// File: src/ctp_checker.sv
// Port-level assertions for the Cartesian-to-polar converter, bound to the top level.
`default_nettype none

module ctp_checker import ctp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        magnitude,
  input logic signed [15:0] angle,
  input logic               angle_valid,
  input logic               last_out
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // An empty output stage always lets a new transaction in.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // A stalled result holds until taken.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(angle)
      && $stable(angle_valid) && $stable(last_out))
    else $error("stalled result changed");

  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !angle_valid |-> angle == SENTINEL_Q11)
    else $error("angle not computed but sentinel missing");

  // A zero modulus means a zero vector, which never passes the threshold.
  a_zero_no_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && magnitude == 16'd0 |-> !angle_valid)
    else $error("angle flagged valid for a zero vector");

endmodule

bind cartesian_to_polar_pixel ctp_checker u_ctp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .magnitude   (out_ch.magnitude),
  .angle       (out_ch.angle),
  .angle_valid (out_ch.angle_valid),
  .last_out    (out_ch.last_out)
);

`default_nettype wire
